// ===== hw/rtl/circ_pkg.sv =====
package circ_pkg;

  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS  = 8;
  localparam int IN_W       = 16;
  localparam int OUT_W      = 32;

  // vertex differences, products, squared lengths, the determinant, cross terms and numerators
  localparam int DIFF_W = COORD_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int LEN_W  = PROD_W + 1;
  localparam int DET_W  = PROD_W + 2;
  localparam int MUL_W  = DIFF_W + LEN_W;
  localparam int NUM_W  = MUL_W + 1;

  // divider: one quotient bit per cell
  localparam int QW     = NUM_W + FRAC_BITS;
  localparam int DMAG_W = DET_W;
  localparam int T_W    = QW + 2;

  localparam int FRONT_STAGES = 6;
  localparam int STAGES       = FRONT_STAGES + QW + 1;

  typedef struct packed {
    logic [IN_W-1:0] ax;
    logic [IN_W-1:0] ay;
    logic [IN_W-1:0] bx;
    logic [IN_W-1:0] by;
    logic [IN_W-1:0] cx;
    logic [IN_W-1:0] cy;
  } pts_t;

  typedef struct packed {
    logic                         neg;
    logic [QW-1:0]                numq;
    logic [DMAG_W-1:0]            rem;
    logic signed [COORD_BITS-1:0] base;
  } lane_t;

  typedef struct packed {
    lane_t [1:0]       lane;
    logic [DMAG_W-1:0] dmag;
    logic              degen;
  } cell_t;

endpackage

// ===== hw/rtl/circ_in_if.sv =====
interface circ_in_if;
  import circ_pkg::*;

  logic            valid;
  logic            ready;
  logic [IN_W-1:0] point_a_x;
  logic [IN_W-1:0] point_a_y;
  logic [IN_W-1:0] point_b_x;
  logic [IN_W-1:0] point_b_y;
  logic [IN_W-1:0] point_c_x;
  logic [IN_W-1:0] point_c_y;

  modport source (output valid, point_a_x, point_a_y, point_b_x, point_b_y,
                  point_c_x, point_c_y, input ready);
  modport sink (input valid, point_a_x, point_a_y, point_b_x, point_b_y,
                point_c_x, point_c_y, output ready);
endinterface

// ===== hw/rtl/circ_out_if.sv =====
interface circ_out_if;
  import circ_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] center_x;
  logic signed [OUT_W-1:0] center_y;
  logic                    degenerate;
  logic                    saturated;

  modport source (output valid, center_x, center_y, degenerate, saturated,
                  input ready);
  modport sink (input valid, center_x, center_y, degenerate, saturated,
                output ready);
endinterface

// ===== hw/rtl/circ_front.sv =====
module circ_front (
  input  logic                                 clk,
  input  logic [circ_pkg::FRONT_STAGES-1:0]    en,
  input  circ_pkg::pts_t                       pts,
  output circ_pkg::cell_t                      q
);
  import circ_pkg::*;

  // stage 0: relative vectors
  logic signed [COORD_BITS-1:0] ax0, ay0;
  logic signed [DIFF_W-1:0]     bx0, by0, cx0, cy0;
  // stage 1: products
  logic signed [COORD_BITS-1:0] ax1, ay1;
  logic signed [DIFF_W-1:0]     bx1, by1, cx1, cy1;
  logic signed [PROD_W-1:0]     pbc, pbycx, sbx, sby, scx, scy;
  // stage 2: determinant and squared lengths
  logic signed [COORD_BITS-1:0] ax2, ay2;
  logic signed [DIFF_W-1:0]     bx2, by2, cx2, cy2;
  logic signed [DET_W-1:0]      d2;
  logic signed [LEN_W-1:0]      lb, lc;
  // stage 3: cross terms
  logic signed [COORD_BITS-1:0] ax3, ay3;
  logic signed [DET_W-1:0]      d3;
  logic signed [MUL_W-1:0]      m_cylb, m_bylc, m_bxlc, m_cxlb;
  // stage 4: numerators
  logic signed [COORD_BITS-1:0] ax4, ay4;
  logic signed [DET_W-1:0]      d4;
  logic signed [NUM_W-1:0]      nx, ny;

  logic signed [COORD_BITS-1:0] sa_x, sa_y, sb_x, sb_y, sc_x, sc_y;
  logic [NUM_W-1:0]             nx_mag, ny_mag;
  logic [DMAG_W-1:0]            d_mag;

  always_comb begin
    sa_x = $signed(pts.ax[COORD_BITS-1:0]);
    sa_y = $signed(pts.ay[COORD_BITS-1:0]);
    sb_x = $signed(pts.bx[COORD_BITS-1:0]);
    sb_y = $signed(pts.by[COORD_BITS-1:0]);
    sc_x = $signed(pts.cx[COORD_BITS-1:0]);
    sc_y = $signed(pts.cy[COORD_BITS-1:0]);
    nx_mag = nx[NUM_W-1] ? NUM_W'(-nx) : NUM_W'(nx);
    ny_mag = ny[NUM_W-1] ? NUM_W'(-ny) : NUM_W'(ny);
    d_mag  = d4[DET_W-1] ? DMAG_W'(-d4) : DMAG_W'(d4);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ax0 <= sa_x;
      ay0 <= sa_y;
      bx0 <= DIFF_W'(sb_x) - DIFF_W'(sa_x);
      by0 <= DIFF_W'(sb_y) - DIFF_W'(sa_y);
      cx0 <= DIFF_W'(sc_x) - DIFF_W'(sa_x);
      cy0 <= DIFF_W'(sc_y) - DIFF_W'(sa_y);
    end
    if (en[1]) begin
      ax1 <= ax0; ay1 <= ay0;
      bx1 <= bx0; by1 <= by0; cx1 <= cx0; cy1 <= cy0;
      pbc   <= PROD_W'(bx0) * PROD_W'(cy0);
      pbycx <= PROD_W'(by0) * PROD_W'(cx0);
      sbx   <= PROD_W'(bx0) * PROD_W'(bx0);
      sby   <= PROD_W'(by0) * PROD_W'(by0);
      scx   <= PROD_W'(cx0) * PROD_W'(cx0);
      scy   <= PROD_W'(cy0) * PROD_W'(cy0);
    end
    if (en[2]) begin
      ax2 <= ax1; ay2 <= ay1;
      bx2 <= bx1; by2 <= by1; cx2 <= cx1; cy2 <= cy1;
      d2 <= (DET_W'(pbc) - DET_W'(pbycx)) <<< 1;
      lb <= LEN_W'(sbx) + LEN_W'(sby);
      lc <= LEN_W'(scx) + LEN_W'(scy);
    end
    if (en[3]) begin
      ax3 <= ax2; ay3 <= ay2; d3 <= d2;
      m_cylb <= MUL_W'(cy2) * MUL_W'(lb);
      m_bylc <= MUL_W'(by2) * MUL_W'(lc);
      m_bxlc <= MUL_W'(bx2) * MUL_W'(lc);
      m_cxlb <= MUL_W'(cx2) * MUL_W'(lb);
    end
    if (en[4]) begin
      ax4 <= ax3; ay4 <= ay3; d4 <= d3;
      nx <= NUM_W'(m_cylb) - NUM_W'(m_bylc);
      ny <= NUM_W'(m_bxlc) - NUM_W'(m_cxlb);
    end
    if (en[5]) begin
      q.lane[0].neg  <= nx[NUM_W-1] ^ d4[DET_W-1];
      q.lane[0].numq <= QW'(nx_mag) << FRAC_BITS;
      q.lane[0].rem  <= '0;
      q.lane[0].base <= ax4;
      q.lane[1].neg  <= ny[NUM_W-1] ^ d4[DET_W-1];
      q.lane[1].numq <= QW'(ny_mag) << FRAC_BITS;
      q.lane[1].rem  <= '0;
      q.lane[1].base <= ay4;
      q.dmag  <= d_mag;
      q.degen <= (d4 == '0);
    end
  end
endmodule

// ===== hw/rtl/circ_div_cell.sv =====
module circ_div_cell (
  input  logic            clk,
  input  logic            en,
  input  circ_pkg::cell_t a,
  output circ_pkg::cell_t q
);
  import circ_pkg::*;

  logic [DMAG_W:0] r2 [2];
  logic [1:0]      ge;
  cell_t           nxt;

  // restoring step, one quotient bit per lane
  always_comb begin
    nxt = a;
    for (int l = 0; l < 2; l++) begin
      r2[l] = {a.lane[l].rem, a.lane[l].numq[QW-1]};
      ge[l] = r2[l] >= {1'b0, a.dmag};
      nxt.lane[l].rem  = ge[l] ? DMAG_W'(r2[l] - {1'b0, a.dmag}) : r2[l][DMAG_W-1:0];
      nxt.lane[l].numq = {a.lane[l].numq[QW-2:0], ge[l]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q <= nxt;
    end
  end
endmodule

// ===== hw/rtl/circ_out.sv =====
module circ_out (
  input  logic                                  clk,
  input  logic                                  en,
  input  circ_pkg::cell_t                       a,
  output logic signed [circ_pkg::OUT_W-1:0]     center_x,
  output logic signed [circ_pkg::OUT_W-1:0]     center_y,
  output logic                                  degenerate,
  output logic                                  saturated
);
  import circ_pkg::*;

  localparam logic signed [T_W-1:0] OUT_MAX = (T_W'(1) <<< (OUT_W - 1)) - T_W'(1);
  localparam logic signed [T_W-1:0] OUT_MIN = -(T_W'(1) <<< (OUT_W - 1));

  logic signed [T_W-1:0]   qv [2];
  logic signed [T_W-1:0]   t  [2];
  logic signed [OUT_W-1:0] res [2];
  logic [1:0]              clip;

  always_comb begin
    for (int l = 0; l < 2; l++) begin
      qv[l] = T_W'(a.lane[l].numq);
      if (a.lane[l].neg) begin
        qv[l] = -qv[l];
      end
      t[l] = qv[l] + (T_W'(a.lane[l].base) <<< FRAC_BITS);
      clip[l] = 1'b0;
      if (t[l] > OUT_MAX) begin
        res[l]  = OUT_MAX[OUT_W-1:0];
        clip[l] = 1'b1;
      end else if (t[l] < OUT_MIN) begin
        res[l]  = OUT_MIN[OUT_W-1:0];
        clip[l] = 1'b1;
      end else begin
        res[l] = t[l][OUT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (a.degen) begin
        center_x   <= '0;
        center_y   <= '0;
        degenerate <= 1'b1;
        saturated  <= 1'b0;
      end else begin
        center_x   <= res[0];
        center_y   <= res[1];
        degenerate <= 1'b0;
        saturated  <= |clip;
      end
    end
  end
endmodule

// ===== hw/rtl/triangle_circumcenter_core.sv =====
// triangle circumcenter core
// tri_in carries one triangle per transaction (three vertices, signed
// integer coordinates); ctr_out returns one transaction per triangle with
// the circumcenter in two's complement, 8 fractional bits, saturated to
// 32 bits, plus degenerate and saturated flags
// the pipeline has 6 arithmetic front stages (differences, products,
// determinant, cross terms, numerators, magnitudes), one cell per quotient
// bit of the radix-2 restoring divider (61 cells, both coordinates side by
// side), then one sign, vertex-add and clamping register that drives ctr_out
// throughput one triangle per cycle while ctr_out keeps taking results
// each stage holds a valid bit and loads whenever it is empty or its
// contents move on, so a stall on ctr_out fills bubbles first and tri_in
// only drops ready once every stage holds a triangle
// reset clears the valid bits only; no state is carried between triangles
module triangle_circumcenter_core (
  input logic          clk,
  input logic          rst,
  circ_in_if.sink      tri_in,
  circ_out_if.source   ctr_out
);
  import circ_pkg::*;

  logic [STAGES-1:0] v;     // stage occupancy
  logic [STAGES:0]   en;    // stage load enables
  pts_t              pts;
  cell_t             chain [QW+1];

  assign en[STAGES] = ctr_out.ready;

  // ready ripples back through empty stages
  for (genvar i = 0; i < STAGES; i++) begin : g_en
    assign en[i] = !v[i] || en[i+1];
  end

  assign tri_in.ready  = en[0];
  assign ctr_out.valid = v[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[0]) begin
        v[0] <= tri_in.valid;
      end
      for (int i = 1; i < STAGES; i++) begin
        if (en[i]) begin
          v[i] <= v[i-1];
        end
      end
    end
  end

  assign pts = '{ax: tri_in.point_a_x, ay: tri_in.point_a_y,
                 bx: tri_in.point_b_x, by: tri_in.point_b_y,
                 cx: tri_in.point_c_x, cy: tri_in.point_c_y};

  // front arithmetic, hands numerators and |d| to the divider
  circ_front u_front (
    .clk (clk),
    .en  (en[FRONT_STAGES-1:0]),
    .pts (pts),
    .q   (chain[0])
  );

  // divider chain, msb of the quotient first
  for (genvar k = 0; k < QW; k++) begin : g_cell
    circ_div_cell u_cell (
      .clk (clk),
      .en  (en[FRONT_STAGES+k]),
      .a   (chain[k]),
      .q   (chain[k+1])
    );
  end

  // sign, add vertex a, clamp
  circ_out u_out (
    .clk        (clk),
    .en         (en[STAGES-1]),
    .a          (chain[QW]),
    .center_x   (ctr_out.center_x),
    .center_y   (ctr_out.center_y),
    .degenerate (ctr_out.degenerate),
    .saturated  (ctr_out.saturated)
  );

`ifndef SYNTHESIS
  // collinear triangle gives a zero centre and never a clamp
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    ctr_out.valid && ctr_out.degenerate |->
      ctr_out.center_x == '0 && ctr_out.center_y == '0 && !ctr_out.saturated)
    else $error("degenerate result with non-zero centre");

  // a clamp leaves at least one coordinate on a bound
  a_sat_bound: assert property (@(posedge clk) disable iff (rst)
    ctr_out.valid && ctr_out.saturated |->
      ctr_out.center_x == 32'sh7fffffff || ctr_out.center_x == 32'sh80000000 ||
      ctr_out.center_y == 32'sh7fffffff || ctr_out.center_y == 32'sh80000000)
    else $error("saturated flag without a clamped coordinate");

  // input back-pressure only when the output is stalled
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !tri_in.ready |-> ctr_out.valid && !ctr_out.ready)
    else $error("input stalled while output is free");
`endif

endmodule

// ===== bench/triangle_circumcenter_core_tb.sv =====
module triangle_circumcenter_core_tb;
  import circ_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // largest quotient kept before scaling
  localparam longint QUOT_LIMIT = longint'(1) <<< 40;
  // cycles without any transaction before the run is abandoned
  localparam int STALL_LIMIT = 4000;
  // drain allowance after the last expected centre has arrived
  localparam int DRAIN_CYCLES = 150;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 660;

  typedef struct {
    logic signed [OUT_W-1:0] cx;
    logic signed [OUT_W-1:0] cy;
    logic                    degen;
    logic                    sat;
  } centre_t;

  logic clk;
  logic rst;

  circ_in_if  tri_in();
  circ_out_if ctr_out();

  triangle_circumcenter_core uut (
    .clk     (clk),
    .rst     (rst),
    .tri_in  (tri_in.sink),
    .ctr_out (ctr_out.source)
  );

  centre_t pending_centres[$];
  int      mismatch_count;
  int      triangles_sent;
  int      centres_seen;
  int      degenerate_seen;
  int      saturated_seen;
  int      sender_idle_pct;
  int      receiver_idle_pct;
  int      quiet_cycles;
  // the ready process starts a long hold-off whenever this token changes
  int      hold_token;
  int      hold_seen;
  int      hold_left;
  bit      input_stalled;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // keep a coordinate to its low COORD_BITS bits, sign extended
  function automatic longint coord_of(logic [IN_W-1:0] raw);
    logic [COORD_BITS-1:0] low;
    low = raw[COORD_BITS-1:0];
    return longint'($signed(low));
  endfunction

  // truncated quotient with FRAC_BITS fraction bits plus the base vertex,
  // clamped to the 32-bit output range
  function automatic logic signed [OUT_W-1:0] scaled_quotient(
    longint num, longint den, longint base, inout logic sat);
    longint one;
    longint q;
    longint r;
    longint f;
    longint t;
    one = longint'(1) <<< FRAC_BITS;
    q = num / den;
    r = num % den;
    f = (r * one) / den;
    if (q > QUOT_LIMIT) q = QUOT_LIMIT;
    if (q < -QUOT_LIMIT) q = -QUOT_LIMIT;
    t = q * one + f + base * one;
    if (t > longint'(32'sh7fffffff)) begin
      sat = 1'b1;
      return 32'sh7fffffff;
    end
    if (t < -longint'(64'sd2147483648)) begin
      sat = 1'b1;
      return 32'sh80000000;
    end
    return t[OUT_W-1:0];
  endfunction

  function automatic centre_t circumcentre_of(pts_t p);
    longint ax, ay, bx, by, cx, cy, det, len_b, len_c;
    centre_t c;
    ax = coord_of(p.ax);
    ay = coord_of(p.ay);
    bx = coord_of(p.bx) - ax;
    by = coord_of(p.by) - ay;
    cx = coord_of(p.cx) - ax;
    cy = coord_of(p.cy) - ay;
    det = 2 * (bx * cy - by * cx);
    len_b = bx * bx + by * by;
    len_c = cx * cx + cy * cy;
    c.sat = 1'b0;
    if (det == 0) begin
      c.cx = '0;
      c.cy = '0;
      c.degen = 1'b1;
      return c;
    end
    c.degen = 1'b0;
    c.cx = scaled_quotient(cy * len_b - by * len_c, det, ax, c.sat);
    c.cy = scaled_quotient(bx * len_c - cx * len_b, det, ay, c.sat);
    return c;
  endfunction

  // one triangle: optional idle gap, then hold valid until ready
  task automatic send_triangle(pts_t p);
    while ($urandom_range(99) < sender_idle_pct) begin
      tri_in.valid <= 1'b0;
      @(posedge clk);
    end
    tri_in.valid     <= 1'b1;
    tri_in.point_a_x <= p.ax;
    tri_in.point_a_y <= p.ay;
    tri_in.point_b_x <= p.bx;
    tri_in.point_b_y <= p.by;
    tri_in.point_c_x <= p.cx;
    tri_in.point_c_y <= p.cy;
    do begin
      @(posedge clk);
      if (!tri_in.ready) input_stalled = 1'b1;
    end while (!tri_in.ready);
    pending_centres.push_back(circumcentre_of(p));
    triangles_sent++;
  endtask

  task automatic send_coords(int ax, int ay, int bx, int by, int cx, int cy);
    pts_t p;
    p.ax = ax[IN_W-1:0];
    p.ay = ay[IN_W-1:0];
    p.bx = bx[IN_W-1:0];
    p.by = by[IN_W-1:0];
    p.cx = cx[IN_W-1:0];
    p.cy = cy[IN_W-1:0];
    send_triangle(p);
  endtask

  function automatic int any_coord();
    return $urandom_range(65535) - 32768;
  endfunction

  function automatic int extreme_coord();
    case ($urandom_range(4))
      0: return -32768;
      1: return 32767;
      2: return -1;
      3: return 0;
      default: return 1;
    endcase
  endfunction

  // random triangle drawn from a few shapes so that saturation, collinear
  // points and ordinary small triangles all turn up often
  task automatic send_random_triangle();
    int ax, ay, bx, by, cx, cy, k;
    int shape;
    shape = $urandom_range(99);
    if (shape < 35) begin
      ax = any_coord(); ay = any_coord(); bx = any_coord();
      by = any_coord(); cx = any_coord(); cy = any_coord();
    end else if (shape < 60) begin
      // small triangle near a random spot
      ax = $urandom_range(60000) - 30000;
      ay = $urandom_range(60000) - 30000;
      bx = ax + $urandom_range(64) - 32; by = ay + $urandom_range(64) - 32;
      cx = ax + $urandom_range(64) - 32; cy = ay + $urandom_range(64) - 32;
    end else if (shape < 72) begin
      // collinear, c on the line through a and b
      ax = $urandom_range(2000) - 1000; ay = $urandom_range(2000) - 1000;
      bx = ax + $urandom_range(200) - 100; by = ay + $urandom_range(200) - 100;
      k = $urandom_range(20) - 10;
      cx = ax + k * (bx - ax); cy = ay + k * (by - ay);
    end else if (shape < 87) begin
      // nearly flat and long, so the centre runs far out
      ax = any_coord(); ay = any_coord();
      bx = any_coord(); by = any_coord();
      cx = bx + $urandom_range(2) - 1; cy = by + $urandom_range(2) - 1;
    end else begin
      ax = extreme_coord(); ay = extreme_coord(); bx = extreme_coord();
      by = extreme_coord(); cx = extreme_coord(); cy = extreme_coord();
    end
    send_coords(ax, ay, bx, by, cx, cy);
  endtask

  // wait for every expected centre, then let the pipeline run empty
  task automatic drain_pipeline();
    tri_in.valid <= 1'b0;
    while (pending_centres.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed();
    sender_idle_pct   = 0;
    receiver_idle_pct <= 0;
    // coincident points and an all-zero triangle
    send_coords(0, 0, 0, 0, 0, 0);
    send_coords(-32768, -32768, -32768, -32768, -32768, -32768);
    // collinear vertices along an axis and a diagonal
    send_coords(0, 0, 5, 0, 10, 0);
    send_coords(-100, -100, 0, 0, 100, 100);
    // right triangle, centre at the hypotenuse midpoint
    send_coords(0, 0, 4, 0, 0, 3);
    send_coords(1, 1, 2, 3, 5, 2);
    // fractional centre that truncates, both signs
    send_coords(0, 0, 1, 0, 0, 1);
    send_coords(0, 0, -3, 1, 2, -7);
    send_coords(3, -5, -7, 2, 1, 9);
    // extreme corners of the coordinate range
    send_coords(-32768, -32768, 32767, -32768, -32768, 32767);
    send_coords(32767, 32767, -32768, 32767, 32767, -32768);
    send_coords(-32768, 32767, 32767, 32767, 0, -32768);
    // nearly flat long triangles, centre clamped positive and negative; then two small right triangles
    send_coords(-32768, -32768, 32767, 32767, 32767, 32766);
    send_coords(-32768, -32768, 32767, 32767, 32766, 32767);
    send_coords(-32768, 0, 32767, 0, 0, 1);
    send_coords(-32768, 0, 32767, 0, 0, -1);
    send_coords(0, -32768, 0, 32767, 1, 0);
    send_coords(0, -32768, 0, 32767, -1, 0);
    send_coords(-1, -1, -1, 0, 0, -1);
    send_coords(32767, 32767, 32766, 32767, 32767, 32766);
    drain_pipeline();
  endtask

  task automatic test_random_phase(int send_idle, int recv_idle, int count);
    sender_idle_pct   = send_idle;
    receiver_idle_pct <= recv_idle;
    repeat (count) send_random_triangle();
    drain_pipeline();
  endtask

  // receiver holds off for a long stretch while triangles keep coming,
  // so every stage fills and the input has to stall
  task automatic test_output_hold();
    sender_idle_pct   = 0;
    receiver_idle_pct <= 0;
    hold_token        <= hold_token + 1;
    repeat (HOLD_CYCLES / 2) send_random_triangle();
    drain_pipeline();
  endtask

  // result side: random ready, with a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      ctr_out.ready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen = hold_token;
      hold_left = HOLD_CYCLES;
      ctr_out.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      ctr_out.ready <= 1'b0;
    end else begin
      ctr_out.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  // compare each returned centre with the oldest prediction
  always @(posedge clk) begin
    centre_t want;
    if (!rst && ctr_out.valid && ctr_out.ready) begin
      centres_seen++;
      if (ctr_out.degenerate) degenerate_seen++;
      if (ctr_out.saturated) saturated_seen++;
      if (pending_centres.size() == 0) begin
        $error("centre returned with no triangle outstanding");
        mismatch_count++;
      end else begin
        want = pending_centres.pop_front();
        if (ctr_out.center_x !== want.cx) begin
          $error("center_x expected %0d actual %0d", want.cx, ctr_out.center_x);
          mismatch_count++;
        end
        if (ctr_out.center_y !== want.cy) begin
          $error("center_y expected %0d actual %0d", want.cy, ctr_out.center_y);
          mismatch_count++;
        end
        if (ctr_out.degenerate !== want.degen) begin
          $error("degenerate expected %0b actual %0b", want.degen,
                 ctr_out.degenerate);
          mismatch_count++;
        end
        if (ctr_out.saturated !== want.sat) begin
          $error("saturated expected %0b actual %0b", want.sat,
                 ctr_out.saturated);
          mismatch_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (tri_in.valid && tri_in.ready) ||
        (ctr_out.valid && ctr_out.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst               = 1'b1;
    tri_in.valid      = 1'b0;
    tri_in.point_a_x  = '0;
    tri_in.point_a_y  = '0;
    tri_in.point_b_x  = '0;
    tri_in.point_b_y  = '0;
    tri_in.point_c_x  = '0;
    tri_in.point_c_y  = '0;
    ctr_out.ready     = 1'b0;
    mismatch_count    = 0;
    triangles_sent    = 0;
    centres_seen      = 0;
    degenerate_seen   = 0;
    saturated_seen    = 0;
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    quiet_cycles      = 0;
    hold_token        = 0;
    hold_seen         = 0;
    hold_left         = 0;
    input_stalled     = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phase(12, 83, PHASE_ITEMS);
    test_random_phase(83, 12, PHASE_ITEMS);
    test_random_phase(0, 0, PHASE_ITEMS);
    test_output_hold();

    $display("%0d triangles sent, %0d centres checked", triangles_sent,
             centres_seen);
    $display("%0d degenerate, %0d clamped, input stall seen: %0b",
             degenerate_seen, saturated_seen, input_stalled);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
